// ----- hw/rtl/fwra_pkg.sv -----
// shared constants, types and helpers of the fifo window running average block
package fwra_pkg;

	localparam int DEPTH    = 8;
	localparam int SAMPLE_W = 16;
	localparam int CAP_W    = 4;
	localparam int HELD_W   = 4;
	localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int SUM_W    = SAMPLE_W + CNT_W;
	localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int STEP_W   = $clog2(SUM_W + 1);

	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(8);

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef struct packed {
		logic                       upd;
		logic                       mode;
		logic signed [SAMPLE_W-1:0] sample;
		logic [CAP_W-1:0]           cap;
	} win_cmd_t;

	typedef struct packed {
		logic                       accepted;
		logic signed [SAMPLE_W-1:0] popped;
		logic [CNT_W-1:0]           count;
		logic signed [SUM_W-1:0]    sum;
	} win_sts_t;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [CNT_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [SUM_W-1:0] quotient;
	} div_rsp_t;

	// capacity register saturated into 1..DEPTH
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
		logic [CMP_W-1:0] c;
		c = CMP_W'(cap);
		if (c == '0) begin
			c = CMP_W'(1);
		end
		if (c > CMP_W'(DEPTH)) begin
			c = CMP_W'(DEPTH);
		end
		return CNT_W'(c);
	endfunction

endpackage

// ----- hw/rtl/fwra_in_if.sv -----
// input item channel: mode and sample with valid/ready
interface fwra_in_if;
	logic                                valid;
	logic                                ready;
	logic                                mode;
	logic signed [fwra_pkg::SAMPLE_W-1:0] sample;

	modport source(output valid, mode, sample, input ready);
	modport sink(input valid, mode, sample, output ready);
endinterface

// ----- hw/rtl/fwra_out_if.sv -----
// result item channel: status, popped sample and mean with valid/ready
interface fwra_out_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 accepted;
	logic signed [fwra_pkg::SAMPLE_W-1:0] popped_value;
	logic signed [fwra_pkg::SAMPLE_W-1:0] average;
	logic                                 average_valid;
	logic [fwra_pkg::HELD_W-1:0]          held_count;

	modport source(output valid, accepted, popped_value, average, average_valid, held_count,
		input ready);
	modport sink(input valid, accepted, popped_value, average, average_valid, held_count,
		output ready);
endinterface

// ----- hw/rtl/fifo_window_running_average.sv -----
// top level: apb capacity register, item sequencer, window and shared divider
// path from input accept to result valid: update, launch, divide steps, done seen, load
// (the load waits until the result register is free)
// one item in flight at a time; the divider gives one quotient bit per cycle of the 20-bit sum
// an empty window skips the divider and goes from launch straight to done
// arst_n clears count, pointer, sum, capacity (to 8) and the sequencer; store contents undefined
module fifo_window_running_average (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fwra_pkg::PADDR_W-1:0]   paddr,
	input  logic [fwra_pkg::PDATA_W-1:0]   pwdata,
	output logic [fwra_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	fwra_in_if.sink                        in_ch,
	fwra_out_if.source                     out_ch
);
	import fwra_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_UPD    = 3'd1;
	localparam logic [2:0] S_LAUNCH = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]                 state_q;
	logic [CAP_W-1:0]           cap_q;
	logic                       mode_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic                       out_valid_q;
	logic                       out_acc_q;
	logic signed [SAMPLE_W-1:0] out_pop_q;
	logic signed [SAMPLE_W-1:0] out_avg_q;
	logic                       out_avalid_q;
	logic [HELD_W-1:0]          out_held_q;

	win_cmd_t cmd;
	win_sts_t sts;
	div_req_t dreq;
	div_rsp_t drsp;

	logic in_take;
	logic out_take;
	logic out_free;
	logic load;

	// apb: single capacity register, always ready
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// handshakes
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_take     = in_ch.valid && in_ch.ready;
	assign out_take    = out_valid_q && out_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign load        = (state_q == S_DONE) && out_free;

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q   <= in_ch.mode;
			sample_q <= in_ch.sample;
		end
	end

	// window update happens in the cycle after accept
	assign cmd.upd    = (state_q == S_UPD);
	assign cmd.mode   = mode_q;
	assign cmd.sample = sample_q;
	assign cmd.cap    = cap_q;

	fwra_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

	// divider sees the post-update sum and count
	assign dreq.start    = (state_q == S_LAUNCH) && (sts.count != '0);
	assign dreq.dividend = sts.sum;
	assign dreq.divisor  = sts.count;

	fwra_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_LAUNCH;
				end
				S_LAUNCH: begin
					// empty window has no mean to compute
					state_q <= (sts.count != '0) ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (drsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_acc_q    <= sts.accepted;
			out_pop_q    <= sts.popped;
			out_avg_q    <= (sts.count != '0) ? drsp.quotient[SAMPLE_W-1:0] : '0;
			out_avalid_q <= (sts.count != '0);
			out_held_q   <= HELD_W'(sts.count);
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.accepted      = out_acc_q;
	assign out_ch.popped_value  = out_pop_q;
	assign out_ch.average       = out_avg_q;
	assign out_ch.average_valid = out_avalid_q;
	assign out_ch.held_count    = out_held_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= CNT_W'(DEPTH))
		else $error("window count beyond depth");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.busy |-> (state_q == S_DIV))
		else $error("divider busy outside divide state");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> !in_ch.ready)
		else $error("item accepted while previous item in flight");

	a_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_acc_q) |-> (out_pop_q == '0))
		else $error("popped value set on a refused item");

	a_avg_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_avalid_q == (out_held_q != '0)))
		else $error("average valid disagrees with held count");

endmodule

// ----- hw/rtl/fwra_window.sv -----
// sample store, pointers, fill count and running sum of the window
module fwra_window (
	input  logic               clk,
	input  logic               arst_n,
	input  fwra_pkg::win_cmd_t cmd,
	output fwra_pkg::win_sts_t sts
);
	import fwra_pkg::*;

	logic signed [SAMPLE_W-1:0] mem [DEPTH];
	logic signed [SAMPLE_W-1:0] rd_q;
	logic [PTR_W-1:0]           rp_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       acc_q;
	logic signed [SAMPLE_W-1:0] pop_q;

	logic                       can_push;
	logic                       can_pop;
	logic [CNT_W:0]             wp_sum;
	logic [PTR_W-1:0]           wp;
	logic [PTR_W-1:0]           rp_next;
	logic signed [SUM_W-1:0]    sample_x;
	logic signed [SUM_W-1:0]    rd_x;

	assign can_push = (cmd.mode == MODE_PUSH) && (cnt_q < eff_cap(cmd.cap));
	assign can_pop  = (cmd.mode == MODE_POP) && (cnt_q != '0);

	// write slot is read pointer plus count, wrapped once
	assign wp_sum  = (CNT_W + 1)'(rp_q) + (CNT_W + 1)'(cnt_q);
	assign wp      = (wp_sum >= (CNT_W + 1)'(DEPTH)) ? PTR_W'(wp_sum - (CNT_W + 1)'(DEPTH))
		: PTR_W'(wp_sum);
	assign rp_next = (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);

	assign sample_x = {{(SUM_W - SAMPLE_W){cmd.sample[SAMPLE_W-1]}}, cmd.sample};
	assign rd_x     = {{(SUM_W - SAMPLE_W){rd_q[SAMPLE_W-1]}}, rd_q};

	always_ff @(posedge clk) begin
		if (cmd.upd && can_push) begin
			mem[wp] <= cmd.sample;
		end
		rd_q <= mem[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			cnt_q <= '0;
			sum_q <= '0;
			acc_q <= 1'b0;
			pop_q <= '0;
		end else if (cmd.upd) begin
			acc_q <= can_push || can_pop;
			pop_q <= can_pop ? rd_q : '0;
			if (can_push) begin
				cnt_q <= cnt_q + CNT_W'(1);
				sum_q <= sum_q + sample_x;
			end else if (can_pop) begin
				rp_q  <= rp_next;
				cnt_q <= cnt_q - CNT_W'(1);
				sum_q <= sum_q - rd_x;
			end
		end
	end

	assign sts.accepted = acc_q;
	assign sts.popped   = pop_q;
	assign sts.count    = cnt_q;
	assign sts.sum      = sum_q;

endmodule

// ----- hw/rtl/fwra_divider.sv -----
// restoring signed divider, one quotient bit per cycle, truncates toward zero
module fwra_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  fwra_pkg::div_req_t req,
	output fwra_pkg::div_rsp_t rsp
);
	import fwra_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic                neg_q;
	logic [CNT_W-1:0]    rem_q;
	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    den_q;

	logic [SUM_W-1:0]    mag;
	logic [CNT_W:0]      shifted;
	logic                fits;

	assign mag     = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[SUM_W-1];
			rem_q <= '0;
			quo_q <= mag;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(shifted - {1'b0, den_q}) : CNT_W'(shifted);
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
